// ----- hw/rtl/scbp_pkg.sv -----
// ============================================================================
// scbp_pkg
// Shared types, constants and helpers of the size class buffer pool.
// ============================================================================
package scbp_pkg;

    localparam int SMALL_BYTES    = 2048;
    localparam int MEDIUM_BYTES   = 8192;
    localparam int LARGE_BYTES    = 32768;
    localparam int BUFS_PER_CLASS = 1024;

    localparam int CLS_N   = 3;
    localparam int CLS_W   = 2;
    localparam int KIND_W  = 2;
    localparam int SIZE_W  = 16;
    localparam int SLOT_W  = 10;
    localparam int STAT_W  = 3;
    localparam int ADDR_W  = 25;
    localparam int BYTES_W = 17;
    localparam int POS_W   = $clog2(BUFS_PER_CLASS);
    localparam int CNT_W   = $clog2(BUFS_PER_CLASS + 1);
    localparam int PROD_W  = SLOT_W + BYTES_W;

    localparam logic [KIND_W-1:0] KIND_ALLOC   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SET_OFS = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK           = 3'd0;
    localparam logic [STAT_W-1:0] STAT_TOO_LARGE    = 3'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY        = 3'd2;
    localparam logic [STAT_W-1:0] STAT_BAD          = 3'd3;
    localparam logic [STAT_W-1:0] STAT_ALREADY_FREE = 3'd4;
    localparam logic [STAT_W-1:0] STAT_OFS_RANGE    = 3'd5;

    typedef logic [CLS_W-1:0]  cls_t;
    typedef logic [SLOT_W-1:0] slot_t;
    typedef logic [SIZE_W-1:0] size_t;
    typedef logic [POS_W-1:0]  pos_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [BYTES_W-1:0] bytes_t;
    typedef logic [CLS_N-1:0][SIZE_W-1:0] size_row_t;

    localparam bytes_t CLASS_BYTES [CLS_N] = '{
        BYTES_W'(SMALL_BYTES), BYTES_W'(MEDIUM_BYTES), BYTES_W'(LARGE_BYTES)
    };

    typedef struct packed {
        logic  rd_en;
        logic  pop;
        logic  push;
        cls_t  cls;
        slot_t slot;
    } fl_cmd_t;

    typedef struct packed {
        logic [CLS_N-1:0] empty;
        logic [CLS_N-1:0] full;
    } fl_status_t;

    typedef struct packed {
        logic  en;
        pos_t  row;
        cls_t  lane;
        size_t data;
    } tbl_wr_t;

    function automatic addr_t byte_addr(cls_t c, slot_t s);
        logic [PROD_W-1:0] prod;
        prod = PROD_W'(s) * PROD_W'(CLASS_BYTES[c]);
        return prod[ADDR_W-1:0];
    endfunction

endpackage

// ----- hw/rtl/scbp_free_list.sv -----
// ============================================================================
// scbp_free_list
// FIFO free lists of all classes in one memory, with heads, tails and counts.
// Positions never written by a release read back as their own index.
// ============================================================================
module scbp_free_list (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  scbp_pkg::fl_cmd_t      cmd,
    output scbp_pkg::slot_t        pop_slot,
    output scbp_pkg::fl_status_t   status
);
    import scbp_pkg::*;

    slot_t mem [CLS_N][BUFS_PER_CLASS];

    pos_t  head_reg [CLS_N];
    pos_t  tail_reg [CLS_N];
    cnt_t  cnt_reg  [CLS_N];
    logic  wrap_reg [CLS_N];

    slot_t rd_data_reg;
    pos_t  rd_pos_reg;
    logic  rd_valid_reg;

    function automatic pos_t pos_inc(pos_t p);
        return (p == POS_W'(BUFS_PER_CLASS - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            mem[cmd.cls][tail_reg[cmd.cls]] <= cmd.slot;
        end
        if (cmd.rd_en) begin
            rd_data_reg  <= mem[cmd.cls][head_reg[cmd.cls]];
            rd_pos_reg   <= head_reg[cmd.cls];
            rd_valid_reg <= wrap_reg[cmd.cls] || (head_reg[cmd.cls] < tail_reg[cmd.cls]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < CLS_N; c++) begin
                head_reg[c] <= '0;
                tail_reg[c] <= '0;
                cnt_reg[c]  <= CNT_W'(BUFS_PER_CLASS);
                wrap_reg[c] <= 1'b0;
            end
        end else begin
            for (int c = 0; c < CLS_N; c++) begin
                if (cmd.pop && cmd.cls == CLS_W'(c)) begin
                    head_reg[c] <= pos_inc(head_reg[c]);
                    cnt_reg[c]  <= cnt_reg[c] - 1'b1;
                end
                if (cmd.push && cmd.cls == CLS_W'(c)) begin
                    tail_reg[c] <= pos_inc(tail_reg[c]);
                    cnt_reg[c]  <= cnt_reg[c] + 1'b1;
                    if (tail_reg[c] == POS_W'(BUFS_PER_CLASS - 1)) begin
                        wrap_reg[c] <= 1'b1;
                    end
                end
            end
        end
    end

    assign pop_slot = rd_valid_reg ? rd_data_reg : SLOT_W'(rd_pos_reg);

    always_comb begin
        for (int c = 0; c < CLS_N; c++) begin
            status.empty[c] = (cnt_reg[c] == '0);
            status.full[c]  = (cnt_reg[c] == CNT_W'(BUFS_PER_CLASS));
        end
    end

    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.pop |-> cnt_reg[cmd.cls] != '0)
        else $error("pop from an empty free list");

    a_push_not_full: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.push |-> cnt_reg[cmd.cls] != CNT_W'(BUFS_PER_CLASS))
        else $error("push into a full free list");

    a_one_op: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.pop && cmd.push))
        else $error("pop and push in the same cycle");

endmodule

// ----- hw/rtl/scbp_size_table.sv -----
// ============================================================================
// scbp_size_table
// Stored size of every buffer, one row per slot with one lane per class.
// Zero marks a free buffer. A sweep after reset zeroes every row.
// ============================================================================
module scbp_size_table (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  rd_en,
    input  scbp_pkg::pos_t        rd_row,
    input  scbp_pkg::tbl_wr_t     wr,
    output scbp_pkg::size_row_t   rd_data,
    output logic                  busy
);
    import scbp_pkg::*;

    size_row_t mem [BUFS_PER_CLASS];

    size_row_t rd_data_reg;
    logic      busy_reg;
    pos_t      clr_reg;

    always_ff @(posedge aclk) begin
        if (busy_reg) begin
            mem[clr_reg] <= '0;
        end else if (wr.en) begin
            mem[wr.row][wr.lane] <= wr.data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_row];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b1;
            clr_reg  <= '0;
        end else if (busy_reg) begin
            clr_reg <= clr_reg + 1'b1;
            if (clr_reg == POS_W'(BUFS_PER_CLASS - 1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    assign rd_data = rd_data_reg;
    assign busy    = busy_reg;

endmodule

// ----- hw/rtl/size_class_buffer_pool_top.sv -----
// ============================================================================
// size_class_buffer_pool_top
// Allocator of fixed-size buffers in three classes with FIFO free lists.
//
//   channel | dir | handshake          | payload
//   s_      | in  | s_valid / s_ready  | kind, size, alignment, offset, class, slot
//   m_      | out | m_valid / m_ready  | status, class, slot, byte address
//
// A request passes in order through accept, memory read, and update with result.
// The free list memory and size table each give one read per request.
// After reset the size table is swept; s_ready stays low until the sweep ends.
// A result waits in the output register; a stalled m_ready holds the update.
// ============================================================================
module size_class_buffer_pool_top (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [scbp_pkg::KIND_W-1:0]  s_kind,
    input  scbp_pkg::size_t              s_req_size,
    input  scbp_pkg::size_t              s_req_alignment,
    input  scbp_pkg::size_t              s_req_offset,
    input  scbp_pkg::cls_t               s_pool_select,
    input  scbp_pkg::slot_t              s_buffer_slot,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [scbp_pkg::STAT_W-1:0]  m_status,
    output scbp_pkg::cls_t               m_granted_class,
    output scbp_pkg::slot_t              m_granted_slot,
    output scbp_pkg::addr_t              m_byte_address
);
    import scbp_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_DECODE = 2'd1;
    localparam logic [1:0] S_EXEC   = 2'd2;

    logic [1:0] state_reg, state_next;

    logic [KIND_W-1:0] kind_reg;
    size_t             size_reg;
    size_t             align_reg;
    size_t             ofs_reg;
    cls_t              sel_reg;
    slot_t             slot_reg;

    logic              m_valid_reg;
    logic [STAT_W-1:0] status_reg, status_next;
    cls_t              cls_reg, cls_next;
    slot_t             gslot_reg, gslot_next;
    addr_t             addr_reg, addr_next;

    fl_cmd_t    fl_cmd;
    fl_status_t fl_stat;
    slot_t      pop_slot;
    tbl_wr_t    tbl_wr;
    size_row_t  size_row;
    logic       tbl_busy;

    logic [CLS_N-1:0] fits;
    logic             align_bad;
    logic             no_fit;
    cls_t             alloc_cls;
    logic             alloc_ok;
    logic             sel_ok;
    logic             release_ok;
    logic             leave;
    size_t            cur_size;

    scbp_free_list u_free_list (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (fl_cmd),
        .pop_slot (pop_slot),
        .status   (fl_stat)
    );

    scbp_size_table u_size_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (state_reg == S_DECODE),
        .rd_row  (POS_W'(slot_reg)),
        .wr      (tbl_wr),
        .rd_data (size_row),
        .busy    (tbl_busy)
    );

    assign s_ready = (state_reg == S_IDLE) && !tbl_busy;
    assign leave   = (state_reg == S_EXEC) && (!m_valid_reg || m_ready);

    always_comb begin
        align_bad = (align_reg == '0) || ((align_reg & (align_reg - 1'b1)) != '0);
        for (int c = 0; c < CLS_N; c++) begin
            fits[c] = ({1'b0, size_reg} <= CLASS_BYTES[c]) &&
                      ({1'b0, align_reg} <= CLASS_BYTES[c]);
        end
        no_fit    = (fits == '0);
        alloc_cls = '0;
        for (int c = CLS_N - 1; c >= 0; c--) begin
            if (fits[c]) begin
                alloc_cls = CLS_W'(c);
            end
        end
        alloc_ok = (kind_reg == KIND_ALLOC) && (size_reg != '0) && !align_bad &&
                   !no_fit && !fl_stat.empty[alloc_cls];
        sel_ok   = (sel_reg < CLS_W'(CLS_N));
        cur_size = sel_ok ? size_row[sel_reg] : '0;
        release_ok = (kind_reg == KIND_RELEASE) && sel_ok && (cur_size != '0);
    end

    always_comb begin
        status_next = STAT_BAD;
        cls_next    = sel_reg;
        gslot_next  = slot_reg;
        addr_next   = '0;
        if (kind_reg == KIND_ALLOC) begin
            cls_next   = '0;
            gslot_next = '0;
            if (size_reg == '0 || align_bad) begin
                status_next = STAT_BAD;
            end else if (no_fit) begin
                status_next = STAT_TOO_LARGE;
            end else if (fl_stat.empty[alloc_cls]) begin
                status_next = STAT_EMPTY;
                cls_next    = alloc_cls;
            end else begin
                status_next = STAT_OK;
                cls_next    = alloc_cls;
                gslot_next  = pop_slot;
                addr_next   = byte_addr(alloc_cls, pop_slot);
            end
        end else if (sel_ok && kind_reg == KIND_RELEASE) begin
            status_next = (cur_size == '0) ? STAT_ALREADY_FREE : STAT_OK;
            addr_next   = byte_addr(sel_reg, slot_reg);
        end else if (sel_ok && kind_reg == KIND_SET_OFS) begin
            status_next = (ofs_reg >= cur_size) ? STAT_OFS_RANGE : STAT_OK;
            addr_next   = byte_addr(sel_reg, slot_reg);
        end
    end

    always_comb begin
        fl_cmd.rd_en = (state_reg == S_DECODE);
        fl_cmd.pop   = leave && alloc_ok;
        fl_cmd.push  = leave && release_ok && !fl_stat.full[sel_reg];
        fl_cmd.cls   = (kind_reg == KIND_ALLOC) ? alloc_cls : sel_reg;
        fl_cmd.slot  = slot_reg;

        tbl_wr.en   = leave && (alloc_ok || release_ok);
        tbl_wr.row  = alloc_ok ? POS_W'(pop_slot) : POS_W'(slot_reg);
        tbl_wr.lane = alloc_ok ? alloc_cls : sel_reg;
        tbl_wr.data = alloc_ok ? size_reg : '0;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid && s_ready) begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                state_next = S_EXEC;
            end
            S_EXEC: begin
                if (leave) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (leave) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            kind_reg  <= s_kind;
            size_reg  <= s_req_size;
            align_reg <= s_req_alignment;
            ofs_reg   <= s_req_offset;
            sel_reg   <= s_pool_select;
            slot_reg  <= s_buffer_slot;
        end
        if (leave) begin
            status_reg <= status_next;
            cls_reg    <= cls_next;
            gslot_reg  <= gslot_next;
            addr_reg   <= addr_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = status_reg;
    assign m_granted_class = cls_reg;
    assign m_granted_slot  = gslot_reg;
    assign m_byte_address  = addr_reg;

    a_accept_decode: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg == S_DECODE)
        else $error("accepted request did not enter decode");

    a_leave_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        leave |=> m_valid && state_reg == S_IDLE)
        else $error("finished request did not present a result");

endmodule
